/* rtl/core/msp_pkg.sv */
// Shared types and codes for the multi-stack shared-pool block.
package msp_pkg;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BAD_ID = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam int unsigned STACK_SEL_W = 4;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CSR_W       = 4;
   localparam logic [CSR_W-1:0] STACKS_IN_USE_RESET = 4'd8;

   typedef struct packed {
      op_type                  opcode;
      logic [STACK_SEL_W-1:0]  stack_sel;
      logic [WORD_W-1:0]       push_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]       pop_value;
      status_type              status;
   } rsp_type;

endpackage

/* rtl/core/msp_pool_ram.sv */
// Pool memory: one write port, one registered read port with write bypass.
module msp_pool_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read in the same cycle as a write to the same entry sees the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/multi_stack_shared_pool.sv */
// Top level: several LIFO stacks sharing one pool of linked entries.
//
// Usage: request words (opcode, stack_sel, push_value) enter on req_valid/req_stall;
// each word yields exactly one response word (pop_value, status) on
// rsp_valid/rsp_stall. A word is taken when valid is high and stall is low.
// The csr channel writes the stacks_in_use register; csr_ready is always high
// and writes are expected only while no request is in flight.
// A taken request is first registered in the execute stage; its response is then
// registered in the response register once the output is not stalled.
// Throughput: one request per cycle while responses are not stalled. At acceptance
// the stack top and free-list head (forwarded from the word still in execution)
// address the link and value memories; the execute cycle then updates tops, free
// list and fill counter and writes the memories.
// Reset (synchronous, active high) empties every stack, empties the free
// list, clears the fill counter and sets stacks_in_use to 8. Memory contents
// are not cleared; unused entries are handed out by the fill counter.
// When the receiver stalls with a response pending, the execute stage holds
// its word and req_stall rises until the response register drains.
module multi_stack_shared_pool #(
   parameter int unsigned MAX_STACKS   = 8,
   parameter int unsigned POOL_ENTRIES = 64,
   parameter int unsigned DATA_WIDTH   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  msp_pkg::req_type                req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output msp_pkg::rsp_type                rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [msp_pkg::CSR_W-1:0]       csr_data
);

   localparam int unsigned AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int unsigned IW = $clog2(POOL_ENTRIES + 1);
   localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam logic [IW-1:0] NULL_IDX = IW'(POOL_ENTRIES);

   // Architectural state.
   logic [IW-1:0]             stack_top_ff [MAX_STACKS];
   logic [IW-1:0]             free_head_ff, free_head_in;
   logic [IW-1:0]             fill_count_ff, fill_count_in;
   logic [msp_pkg::CSR_W-1:0] stacks_in_use_ff;

   // Execute stage.
   logic                            b_valid_ff, b_valid_in;
   msp_pkg::op_type                 b_op_ff;
   logic [msp_pkg::STACK_SEL_W-1:0] b_id_ff;
   logic                            b_bad_ff;
   logic [DATA_WIDTH-1:0]           b_value_ff;
   logic [IW-1:0]                   b_top_ff;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   msp_pkg::rsp_type rsp_word_ff;

   logic accept, exec;
   logic id_ok;
   logic [SW-1:0] req_sid;
   logic [IW-1:0] top_eff;
   logic [IW-1:0] link_rd_ptr;
   logic [63:0]   push_wide;
   logic [63:0]   pop_wide;

   logic [IW-1:0]         link_rd;
   logic [DATA_WIDTH-1:0] value_rd;

   logic                  free_avail, fill_avail, full, empty;
   logic [IW-1:0]         alloc_idx;
   logic                  push_ok, pop_ok;
   logic                  top_we;
   logic [IW-1:0]         top_new;
   logic                  link_we, value_we;
   logic [AW-1:0]         link_waddr;
   logic [IW-1:0]         link_wdata;
   msp_pkg::status_type   status;
   msp_pkg::rsp_type      rsp_new;

   // Handshakes.
   assign exec      = b_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = b_valid_ff && !exec;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Execute decisions on the word held in the execute stage.
   assign free_avail = (free_head_ff != NULL_IDX);
   assign fill_avail = (fill_count_ff != NULL_IDX);
   assign full       = !free_avail && !fill_avail;
   assign alloc_idx  = free_avail ? free_head_ff : fill_count_ff;
   assign empty      = (b_top_ff == NULL_IDX);
   assign push_ok    = exec && !b_bad_ff && (b_op_ff == msp_pkg::OP_PUSH) && !full;
   assign pop_ok     = exec && !b_bad_ff && (b_op_ff == msp_pkg::OP_POP) && !empty;
   assign top_we     = push_ok || pop_ok;
   assign top_new    = push_ok ? alloc_idx : link_rd;

   // A push links the new entry to the old top; a pop puts its entry on the free list.
   assign link_we    = push_ok || pop_ok;
   assign link_waddr = push_ok ? alloc_idx[AW-1:0] : b_top_ff[AW-1:0];
   assign link_wdata = push_ok ? b_top_ff : free_head_ff;
   assign value_we   = push_ok;

   always_comb begin
      free_head_in  = free_head_ff;
      fill_count_in = fill_count_ff;
      if (push_ok) begin
         if (free_avail) begin
            free_head_in = link_rd;
         end else begin
            fill_count_in = IW'(fill_count_ff + 1'b1);
         end
      end else if (pop_ok) begin
         free_head_in = b_top_ff;
      end
   end

   always_comb begin
      if (b_bad_ff) begin
         status = msp_pkg::ST_BAD_ID;
      end else if ((b_op_ff == msp_pkg::OP_PUSH) && full) begin
         status = msp_pkg::ST_FULL;
      end else if ((b_op_ff == msp_pkg::OP_POP) && empty) begin
         status = msp_pkg::ST_EMPTY;
      end else begin
         status = msp_pkg::ST_OK;
      end
   end

   assign pop_wide          = 64'(value_rd);
   assign rsp_new.pop_value = pop_ok ? pop_wide[msp_pkg::WORD_W-1:0] : '0;
   assign rsp_new.status    = status;

   // Read side for the incoming word, with the executing word's updates forwarded.
   assign req_sid = req_word.stack_sel[SW-1:0];
   assign id_ok   = (req_word.stack_sel < stacks_in_use_ff) &&
                    (5'(req_word.stack_sel) < 5'(MAX_STACKS));

   always_comb begin
      if (!id_ok) begin
         top_eff = NULL_IDX;
      end else if (top_we && (b_id_ff == req_word.stack_sel)) begin
         top_eff = top_new;
      end else begin
         top_eff = stack_top_ff[req_sid];
      end
   end

   assign link_rd_ptr = (req_word.opcode == msp_pkg::OP_POP) ? top_eff : free_head_in;
   assign push_wide   = {32'b0, req_word.push_value};

   msp_pool_ram #(
      .DEPTH (POOL_ENTRIES),
      .WIDTH (IW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (accept),
      .rd_addr (link_rd_ptr[AW-1:0]),
      .rd_data (link_rd)
   );

   msp_pool_ram #(
      .DEPTH (POOL_ENTRIES),
      .WIDTH (DATA_WIDTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (alloc_idx[AW-1:0]),
      .wr_data (b_value_ff),
      .rd_en   (accept),
      .rd_addr (top_eff[AW-1:0]),
      .rd_data (value_rd)
   );

   // Stage and response control.
   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (exec) begin
         b_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         free_head_ff     <= NULL_IDX;
         fill_count_ff    <= '0;
         stacks_in_use_ff <= msp_pkg::STACKS_IN_USE_RESET;
         for (int i = 0; i < MAX_STACKS; i++) begin
            stack_top_ff[i] <= NULL_IDX;
         end
      end else begin
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_head_ff  <= free_head_in;
         fill_count_ff <= fill_count_in;
         if (csr_valid && csr_ready) begin
            stacks_in_use_ff <= csr_data;
         end
         if (top_we) begin
            stack_top_ff[b_id_ff[SW-1:0]] <= top_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_op_ff    <= req_word.opcode;
         b_id_ff    <= req_word.stack_sel;
         b_bad_ff   <= !id_ok;
         b_value_ff <= push_wide[DATA_WIDTH-1:0];
         b_top_ff   <= top_eff;
      end
      if (exec) begin
         rsp_word_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The fill counter never runs past the pool.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= NULL_IDX)
      else $error("fill counter past pool size");

   // Every freed entry was handed out by the fill counter earlier.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == NULL_IDX) || (free_head_ff < fill_count_ff))
      else $error("free list head points at an untouched entry");

   // An executed word always leaves a response in the output register.
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed word produced no response");

   // A word that is taken reaches the execute stage in the next cycle.
   a_accept_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted word lost before execution");

endmodule
